// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps

package bsc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_CAL       = 2'd0;
    localparam logic [1:0] REG_PRESS_CAL_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_HIGH = 2'd2;
    localparam logic [1:0] REG_PRESS_CAL_LAST = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_OUT_RANGE = 2'd2;

    // Compensation constants
    localparam logic [32:0] PRESS_OFFSET_FINE = 33'd128000;
    localparam logic [20:0] PRESS_RAW_BASE    = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE       = 64'd3125;
    localparam logic signed [63:0] PRESS_MIN_Q8 = 64'sd7680000;
    localparam logic signed [63:0] PRESS_MAX_Q8 = 64'sd28160000;
    localparam logic [31:0] TEMP_ROUND        = 32'd128;
    localparam logic [63:0] VAR1_BIAS         = 64'h0000_8000_0000_0000;

    // Divider depth: one restoring step per quotient bit
    localparam int DIV_BITS = 64;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [24:0]        pressure_q8;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_calib;

    // Temperature results and the divisor-zero flag ride alongside the pressure path
    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic        div_zero;
    } t_side;

endpackage

// ===== rtl/baro_sensor_compensation.sv =====
`timescale 1ns / 1ps

// Barometric sensor compensation engine. Each request carries one raw temperature and one
// raw pressure sample; the result carries temperature in hundredths of a degree, the fine
// temperature, pressure in pascals times 256 and a status (divisor zero, or pressure out
// of the plausible range, both force pressure to zero). The pipeline takes one request
// per clock unless the output is stalled and passes it through 8 stages of temperature and
// coefficient arithmetic, 66 stages of the signed 64-bit divider (one quotient bit per
// stage plus sign handling), and 5 stages of correction and range check. A stalled
// output holds the whole pipeline; nothing is dropped. Write calibration only while the
// pipeline is empty.

module baro_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample requests
    input  logic               i_valid,
    output logic               o_stall,
    input  bsc_pkg::t_in_item  i_item,
    // results
    output logic               o_valid,
    input  logic               i_stall,
    output bsc_pkg::t_out_item o_item,
    // calibration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import bsc_pkg::*;

    logic [47:0] r_temp_cal;
    logic [63:0] r_pcal_low;
    logic [63:0] r_pcal_high;
    logic [15:0] r_pcal_last;
    t_calib      cal;

    logic        en;
    logic        fr_valid, dv_valid;
    logic [63:0] fr_num, fr_den, dv_quo;
    t_side       fr_side, dv_side;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal  <= '0;
            r_pcal_low  <= '0;
            r_pcal_high <= '0;
            r_pcal_last <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMP_CAL:       r_temp_cal  <= i_cfg_data[47:0];
                REG_PRESS_CAL_LOW:  r_pcal_low  <= i_cfg_data;
                REG_PRESS_CAL_HIGH: r_pcal_high <= i_cfg_data;
                REG_PRESS_CAL_LAST: r_pcal_last <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // unpack calibration words
    assign cal.t1 = r_temp_cal[15:0];
    assign cal.t2 = $signed(r_temp_cal[31:16]);
    assign cal.t3 = $signed(r_temp_cal[47:32]);
    assign cal.p1 = r_pcal_low[15:0];
    assign cal.p2 = $signed(r_pcal_low[31:16]);
    assign cal.p3 = $signed(r_pcal_low[47:32]);
    assign cal.p4 = $signed(r_pcal_low[63:48]);
    assign cal.p5 = $signed(r_pcal_high[15:0]);
    assign cal.p6 = $signed(r_pcal_high[31:16]);
    assign cal.p7 = $signed(r_pcal_high[47:32]);
    assign cal.p8 = $signed(r_pcal_high[63:48]);
    assign cal.p9 = $signed(r_pcal_last);

    // advance every stage together unless the result at the output is held
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_cal   (cal),
        .o_valid (fr_valid),
        .o_num   (fr_num),
        .o_den   (fr_den),
        .o_side  (fr_side)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .i_side  (fr_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_side  (dv_side),
        .i_cal   (cal),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ===== rtl/bsc_front.sv =====
`timescale 1ns / 1ps

module bsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  bsc_pkg::t_in_item i_item,
    input  bsc_pkg::t_calib  i_cal,
    output logic             o_valid,
    output logic [63:0]      o_num,
    output logic [63:0]      o_den,
    output bsc_pkg::t_side   o_side
);
    import bsc_pkg::*;

    logic [7:0] r_valid;

    // stage 1
    logic [31:0] n_x1, n_dt;
    logic [31:0] r1_ta, r1_dsq;
    logic [19:0] r1_adc_p;
    // stage 2
    logic [31:0] n_dsh;
    logic [31:0] r2_a, r2_bm;
    logic [19:0] r2_adc_p;
    // stage 3
    logic [31:0] r3_fine;
    logic [19:0] r3_adc_p;
    // stage 4
    logic [31:0] n_f5;
    logic signed [32:0] n_v1;
    logic signed [65:0] n_sq;
    logic signed [48:0] n_v1p5, n_v1p2;
    logic [31:0] r4_centi, r4_fine;
    logic [63:0] r4_v1sq;
    logic [48:0] r4_v1p5, r4_v1p2;
    logic [19:0] r4_adc_p;
    // stage 5
    logic signed [79:0] n_v2m, n_v1m;
    logic [31:0] r5_centi, r5_fine;
    logic [63:0] r5_v2a, r5_v1a;
    logic [48:0] r5_v1p5, r5_v1p2;
    logic [19:0] r5_adc_p;
    // stage 6
    logic [31:0] r6_centi, r6_fine;
    logic [63:0] r6_v2, r6_v1n;
    logic [19:0] r6_adc_p;
    // stage 7
    logic signed [80:0] n_pm;
    logic [20:0] n_praw;
    logic [31:0] r7_centi, r7_fine;
    logic [63:0] r7_v1m, r7_np;
    // stage 8
    logic [63:0] n_den;
    logic [63:0] r8_num, r8_den;
    t_side       r8_side;

    assign n_x1  = {15'd0, i_item.raw_temperature[19:3]} - {15'd0, i_cal.t1, 1'b0};
    assign n_dt  = {16'd0, i_item.raw_temperature[19:4]} - {16'd0, i_cal.t1};
    assign n_dsh = 32'($signed(r1_dsq) >>> 12);
    assign n_f5  = {r3_fine[29:0], 2'b00} + r3_fine + TEMP_ROUND;
    assign n_v1  = $signed({r3_fine[31], r3_fine} - PRESS_OFFSET_FINE);
    assign n_sq  = n_v1 * n_v1;
    assign n_v1p5 = n_v1 * i_cal.p5;
    assign n_v1p2 = n_v1 * i_cal.p2;
    assign n_v2m = $signed(r4_v1sq) * i_cal.p6;
    assign n_v1m = $signed(r4_v1sq) * i_cal.p3;
    assign n_pm  = $signed(r6_v1n + VAR1_BIAS) * $signed({1'b0, i_cal.p1});
    assign n_praw = PRESS_RAW_BASE - {1'b0, r6_adc_p};
    assign n_den = 64'($signed(r7_v1m) >>> 33);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // temperature products
            r1_ta    <= n_x1 * {{16{i_cal.t2[15]}}, i_cal.t2};
            r1_dsq   <= n_dt * n_dt;
            r1_adc_p <= i_item.raw_pressure;

            r2_a     <= 32'($signed(r1_ta) >>> 11);
            r2_bm    <= n_dsh * {{16{i_cal.t3[15]}}, i_cal.t3};
            r2_adc_p <= r1_adc_p;

            r3_fine  <= r2_a + 32'($signed(r2_bm) >>> 14);
            r3_adc_p <= r2_adc_p;

            // centi and first pressure products
            r4_centi <= 32'($signed(n_f5) >>> 8);
            r4_fine  <= r3_fine;
            r4_v1sq  <= n_sq[63:0];
            r4_v1p5  <= n_v1p5;
            r4_v1p2  <= n_v1p2;
            r4_adc_p <= r3_adc_p;

            r5_centi <= r4_centi;
            r5_fine  <= r4_fine;
            r5_v2a   <= n_v2m[63:0];
            r5_v1a   <= n_v1m[63:0];
            r5_v1p5  <= r4_v1p5;
            r5_v1p2  <= r4_v1p2;
            r5_adc_p <= r4_adc_p;

            // sum the var2 and var1 terms
            r6_centi <= r5_centi;
            r6_fine  <= r5_fine;
            r6_v2    <= r5_v2a + {r5_v1p5[46:0], 17'd0}
                        + {{13{i_cal.p4[15]}}, i_cal.p4, 35'd0};
            r6_v1n   <= 64'($signed(r5_v1a) >>> 8)
                        + {{3{r5_v1p2[48]}}, r5_v1p2, 12'd0};
            r6_adc_p <= r5_adc_p;

            r7_centi <= r6_centi;
            r7_fine  <= r6_fine;
            r7_v1m   <= n_pm[63:0];
            r7_np    <= {12'd0, n_praw, 31'd0} - r6_v2;

            r8_num         <= 64'(r7_np * PRESS_SCALE);
            r8_den         <= n_den;
            r8_side.centi  <= r7_centi;
            r8_side.fine   <= r7_fine;
            r8_side.div_zero <= (n_den == 64'd0);
        end
    end

    assign o_valid = r_valid[7];
    assign o_num   = r8_num;
    assign o_den   = r8_den;
    assign o_side  = r8_side;

endmodule

// ===== rtl/bsc_div.sv =====
`timescale 1ns / 1ps

module bsc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_num,
    input  logic [63:0]    i_den,
    input  bsc_pkg::t_side i_side,
    output logic           o_valid,
    output logic [63:0]    o_quo,
    output bsc_pkg::t_side o_side
);
    import bsc_pkg::*;

    logic        r_valid [0:DIV_BITS];
    logic [63:0] r_rem   [0:DIV_BITS];
    logic [63:0] r_dvd   [0:DIV_BITS];
    logic [63:0] r_den   [0:DIV_BITS];
    logic        r_neg   [0:DIV_BITS];
    t_side       r_side  [0:DIV_BITS];

    logic        r_out_valid;
    logic [63:0] r_quo;
    t_side       r_out_side;

    // stage 0: take magnitudes, note the quotient sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_dvd[0]  <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_den[0]  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_side[0] <= i_side;
        end
    end

    // one restoring step per stage, quotient bits shift in behind the dividend
    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
        logic [64:0] n_shift;
        logic [64:0] n_diff;
        logic        n_ge;

        assign n_shift = {r_rem[k-1], r_dvd[k-1][63]};
        assign n_diff  = n_shift - {1'b0, r_den[k-1]};
        assign n_ge    = ~n_diff[64];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[63:0] : n_shift[63:0];
                r_dvd[k]  <= {r_dvd[k-1][62:0], n_ge};
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // restore the sign; the most negative value over minus one wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo      <= r_neg[DIV_BITS] ? (64'd0 - r_dvd[DIV_BITS]) : r_dvd[DIV_BITS];
            r_out_side <= r_side[DIV_BITS];
        end
    end

    assign o_valid = r_out_valid;
    assign o_quo   = r_quo;
    assign o_side  = r_out_side;

endmodule

// ===== rtl/bsc_back.sv =====
`timescale 1ns / 1ps

module bsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_quo,
    input  bsc_pkg::t_side     i_side,
    input  bsc_pkg::t_calib    i_cal,
    output logic               o_valid,
    output bsc_pkg::t_out_item o_item
);
    import bsc_pkg::*;

    logic [4:0] r_valid;

    logic [63:0] n_h;
    logic [63:0] n_hlsq;
    logic [31:0] n_hlhh;
    logic signed [79:0] n_w2m, n_w1m;
    logic [63:0] n_sum;
    logic signed [63:0] n_p;

    logic [63:0] r1_q, r1_hlsq, r1_w2m;
    logic [30:0] r1_hlhh;
    t_side       r1_side;
    logic [63:0] r2_q, r2_hsq, r2_w2;
    t_side       r2_side;
    logic [63:0] r3_q, r3_w1m, r3_w2;
    t_side       r3_side;
    logic [63:0] r4_sum;
    t_side       r4_side;
    t_out_item   r5_item;

    assign n_h    = 64'($signed(i_quo) >>> 13);
    assign n_hlsq = n_h[31:0] * n_h[31:0];
    assign n_hlhh = n_h[31:0] * n_h[63:32];
    assign n_w2m  = $signed(i_quo) * i_cal.p8;
    assign n_w1m  = $signed(r2_hsq) * i_cal.p9;
    assign n_sum  = r3_q + 64'($signed(r3_w1m) >>> 25) + r3_w2;
    assign n_p    = $signed(64'($signed(r4_sum) >>> 8)
                    + {{44{i_cal.p7[15]}}, i_cal.p7, 4'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // split h*h into 32-bit partial products
            r1_q    <= i_quo;
            r1_hlsq <= n_hlsq;
            r1_hlhh <= n_hlhh[30:0];
            r1_w2m  <= n_w2m[63:0];
            r1_side <= i_side;

            r2_q    <= r1_q;
            r2_hsq  <= r1_hlsq + {r1_hlhh, 33'd0};
            r2_w2   <= 64'($signed(r1_w2m) >>> 19);
            r2_side <= r1_side;

            r3_q    <= r2_q;
            r3_w1m  <= n_w1m[63:0];
            r3_w2   <= r2_w2;
            r3_side <= r2_side;

            r4_sum  <= n_sum;
            r4_side <= r3_side;

            r5_item.temperature_centi <= $signed(r4_side.centi);
            r5_item.fine_temperature  <= $signed(r4_side.fine);
            if (r4_side.div_zero) begin
                r5_item.status      <= ST_DIV_ZERO;
                r5_item.pressure_q8 <= '0;
            end else if (n_p < PRESS_MIN_Q8 || n_p > PRESS_MAX_Q8) begin
                r5_item.status      <= ST_OUT_RANGE;
                r5_item.pressure_q8 <= '0;
            end else begin
                r5_item.status      <= ST_OK;
                r5_item.pressure_q8 <= n_p[24:0];
            end
        end
    end

    assign o_valid = r_valid[4];
    assign o_item  = r5_item;

endmodule

// ===== rtl/bsc_checker.sv =====
`timescale 1ns / 1ps

module bsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input bsc_pkg::t_out_item o_item
);
    import bsc_pkg::*;

    // a held result must hold the request side too
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("held result did not stall requests");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("held result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status != ST_OK) |-> (o_item.pressure_q8 == 25'd0))
        else $error("pressure nonzero with error status");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status == ST_OK) |->
        (o_item.pressure_q8 >= 25'd7680000 && o_item.pressure_q8 <= 25'd28160000))
        else $error("valid pressure outside range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.status == ST_OK || o_item.status == ST_DIV_ZERO
                     || o_item.status == ST_OUT_RANGE))
        else $error("undefined status code");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ===== sim/baro_sensor_compensation_test.sv =====
`timescale 1ns / 1ps

module baro_sensor_compensation_test;
    import bsc_pkg::*;

    localparam int LATENCY = 79;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 600;

    // Compensation arithmetic and the queue of pending results.
    class compensation_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_low;
        logic [63:0] press_high;
        logic [15:0] press_last;
        t_out_item   pending[$];
        int          errors;

        function new();
            temp_cal = '0;
            press_low = '0;
            press_high = '0;
            press_last = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                REG_TEMP_CAL: temp_cal = data[47:0];
                REG_PRESS_CAL_LOW: press_low = data;
                REG_PRESS_CAL_HIGH: press_high = data;
                REG_PRESS_CAL_LAST: press_last = data[15:0];
                default: ;
            endcase
        endfunction

        function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
            logic [63:0] ma, mb, q;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        // Compute the expected result of one request and queue it.
        function void note_request(t_in_item req);
            logic [31:0] t1, t2, t3, adc_t, a, d, b, fine, centi;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] v1, v2, p, h, w1, w2;
            t_out_item res;
            adc_t = {12'd0, req.raw_temperature};
            t1 = {16'd0, temp_cal[15:0]};
            t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
            t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
            a = $signed(((adc_t >> 3) - (t1 << 1)) * t2) >>> 11;
            d = (adc_t >> 4) - t1;
            b = $signed($signed(d * d) >>> 12) * $signed(t3);
            b = $signed(b) >>> 14;
            fine = a + b;
            centi = $signed(fine * 32'd5 + 32'd128) >>> 8;

            p1 = {48'd0, press_low[15:0]};
            p2 = $signed(press_low[31:16]);
            p3 = $signed(press_low[47:32]);
            p4 = $signed(press_low[63:48]);
            p5 = $signed(press_high[15:0]);
            p6 = $signed(press_high[31:16]);
            p7 = $signed(press_high[47:32]);
            p8 = $signed(press_high[63:48]);
            p9 = $signed(press_last);

            v1 = $signed(fine) - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

            res.temperature_centi = centi;
            res.fine_temperature = fine;
            res.pressure_q8 = '0;
            if (v1 == 0) begin
                res.status = ST_DIV_ZERO;
            end else begin
                p = 64'sd1048576 - $signed({44'd0, req.raw_pressure});
                p = sdiv(((p <<< 31) - v2) * 64'sd3125, v1);
                h = p >>> 13;
                w1 = (p9 * h * h) >>> 25;
                w2 = (p8 * p) >>> 19;
                p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
                if (p < 64'sd7680000 || p > 64'sd28160000) begin
                    res.status = ST_OUT_RANGE;
                end else begin
                    res.status = ST_OK;
                    res.pressure_q8 = p[24:0];
                end
            end
            pending.push_back(res);
        endfunction

        // Compare one result against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp_res;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.temperature_centi !== exp_res.temperature_centi) begin
                $error("temperature_centi exp %0d got %0d",
                       exp_res.temperature_centi, got.temperature_centi);
                errors++;
            end
            if (got.fine_temperature !== exp_res.fine_temperature) begin
                $error("fine_temperature exp %0d got %0d",
                       exp_res.fine_temperature, got.fine_temperature);
                errors++;
            end
            if (got.pressure_q8 !== exp_res.pressure_q8) begin
                $error("pressure_q8 exp %0d got %0d", exp_res.pressure_q8, got.pressure_q8);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $error("status exp %0d got %0d", exp_res.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    compensation_scoreboard board;
    bit quiet_tail;
    int idle_cycles;

    baro_sensor_compensation dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item(i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item(o_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_TEMP_CAL;
        i_cfg_data = '0;
    end

    // Check results and count handshake-free cycles for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_result(o_item);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("baro_sensor_compensation test failed");
                $finish;
            end
        end
    end

    // Receiver: stall in random bursts, none in the quiet tail.
    initial begin
        int burst;
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic write_cal(logic [1:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    // Present one request and hold it until accepted.
    task automatic send_request(logic [19:0] raw_t, logic [19:0] raw_p);
        t_in_item req;
        req.raw_temperature = raw_t;
        req.raw_pressure = raw_p;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(req);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Typical datasheet calibration, with optional random perturbation.
    task automatic load_typical(bit jitter);
        logic [15:0] t1, p1;
        logic [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = 16'd27504; t2 = 16'd26435; t3 = -16'sd1000;
        p1 = 16'd36477; p2 = -16'sd10685; p3 = 16'd3024; p4 = 16'd2855;
        p5 = 16'd140; p6 = -16'sd7; p7 = 16'd15500; p8 = -16'sd14600; p9 = 16'd6000;
        if (jitter) begin
            t1 += 16'($urandom_range(0, 2000)) - 16'd1000;
            t2 += 16'($urandom_range(0, 400)) - 16'd200;
            p1 += 16'($urandom_range(0, 4000)) - 16'd2000;
            p2 += 16'($urandom_range(0, 400)) - 16'd200;
            p8 += 16'($urandom_range(0, 400)) - 16'd200;
            p9 += 16'($urandom_range(0, 400)) - 16'd200;
        end
        write_cal(REG_TEMP_CAL, {16'd0, t3, t2, t1});
        write_cal(REG_PRESS_CAL_LOW, {p4, p3, p2, p1});
        write_cal(REG_PRESS_CAL_HIGH, {p8, p7, p6, p5});
        write_cal(REG_PRESS_CAL_LAST, {48'd0, p9});
    endtask

    initial begin
        logic [19:0] rt, rp;
        board = new();
        quiet_tail = 0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero calibration: divisor zero.
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        drain();

        // Typical calibration: valid results and field extremes.
        load_typical(0);
        send_request(20'd519888, 20'd415148);
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'd0, 20'hFFFFF);
        send_request(20'hFFFFF, 20'd0);
        send_request(20'd519888, 20'd0);
        send_request(20'd519888, 20'hFFFFF);
        drain();

        // All-ones calibration words, then extreme signed words.
        write_cal(REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(20'hFFFFF, 20'h00000);
        send_request(20'h00000, 20'hFFFFF);
        drain();
        write_cal(REG_TEMP_CAL, 64'h8000_7FFF_FFFF);
        write_cal(REG_PRESS_CAL_LOW, 64'h7FFF_8000_7FFF_FFFF);
        write_cal(REG_PRESS_CAL_HIGH, 64'h8000_7FFF_8000_7FFF);
        write_cal(REG_PRESS_CAL_LAST, 64'h8000);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'h00000, 20'h00000);
        send_request(20'h80000, 20'h80000);
        drain();

        // Random phases: mostly realistic calibration, some raw random words.
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 4 == 3) begin
                write_cal(REG_TEMP_CAL, {$urandom(), $urandom()});
                write_cal(REG_PRESS_CAL_LOW, {$urandom(), $urandom()});
                write_cal(REG_PRESS_CAL_HIGH, {$urandom(), $urandom()});
                write_cal(REG_PRESS_CAL_LAST, {$urandom(), $urandom()});
            end else begin
                load_typical(1);
            end
            if (phase == 11) quiet_tail = 1;
            for (int n = 0; n < RANDOM_ITEMS / 12; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    rt = 20'($urandom_range(0, 20'hFFFFF));
                    rp = 20'($urandom_range(0, 20'hFFFFF));
                end else begin
                    rt = 20'($urandom_range(400000, 640000));
                    rp = 20'($urandom_range(200000, 600000));
                end
                send_request(rt, rp);
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("baro_sensor_compensation test passed");
        end else begin
            $display("baro_sensor_compensation test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bsc_pkg.sv
rtl/bsc_front.sv
rtl/bsc_div.sv
rtl/bsc_back.sv
rtl/baro_sensor_compensation.sv
rtl/bsc_checker.sv
sim/baro_sensor_compensation_test.sv
